// ===== sv/rlfp_pkg.sv =====
// shared types, register codes and reset values for the rc link frame parser
`timescale 1ns / 1ps

package rlfp_pkg;

  localparam int FRAME_BYTES_DEF  = 64;
  localparam int NUM_CHANNELS_DEF = 16;
  localparam int CHANNEL_BITS_DEF = 11;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RC_FRAME_TYPE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLYNOMIAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RC_LENGTH  = 3'd3;

  localparam logic [7:0] SYNC_BYTE_RST      = 8'd200;
  localparam logic [7:0] RC_FRAME_TYPE_RST  = 8'd22;
  localparam logic [7:0] CRC_POLYNOMIAL_RST = 8'd213;
  localparam logic [5:0] MIN_RC_LENGTH_RST  = 6'd24;

  localparam int MIN_LEN_EXCL = 3;
  localparam int FIRST_PAYLOAD = 3;
  localparam int TYPE_POS = 2;

  localparam int PWM_CENTER = 1500;
  localparam int RAW_CENTER = 992;
  localparam int PWM_MIN = 1000;
  localparam int PWM_MAX = 2000;

  typedef enum logic [2:0] {
    S_WAIT,
    S_LEN,
    S_BODY,
    S_READ,
    S_LOAD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take_sync;
    logic take_len;
    logic take_body;
    logic abort;
    logic end_frame;
    logic rd_issue;
    logic rd_load;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic sync_match;
    logic len_ok;
    logic body_done;
    logic pass_now;
    logic frame_ok;
    logic have_enough;
    logic out_free;
    logic last_ch;
  } status_t;

endpackage

// ===== sv/rlfp_ram.sv =====
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module rlfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rlfp_ctrl.sv =====
// parser and unpack sequencer for the rc link frame parser
`timescale 1ns / 1ps

module rlfp_ctrl import rlfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   take;

  assign take = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_WAIT: begin
        s_tready = 1'b1;
        if (take && st.sync_match) begin
          cmd.take_sync = 1'b1;
          state_next    = S_LEN;
        end
      end
      S_LEN: begin
        s_tready = 1'b1;
        if (take) begin
          if (st.len_ok) begin
            cmd.take_len = 1'b1;
            state_next   = S_BODY;
          end else begin
            cmd.abort  = 1'b1;
            state_next = S_WAIT;
          end
        end
      end
      S_BODY: begin
        s_tready = 1'b1;
        if (take) begin
          cmd.take_body = 1'b1;
          if (st.body_done) begin
            cmd.end_frame = 1'b1;
            state_next    = st.pass_now ? S_READ : S_EMIT;
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_next   = S_LOAD;
      end
      S_LOAD: begin
        cmd.rd_load = 1'b1;
        state_next  = S_EMIT;
      end
      S_EMIT: begin
        if (st.frame_ok && !st.have_enough) begin
          state_next = S_READ;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.last_ch) begin
            state_next = S_WAIT;
          end
        end
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> st.out_free)
    else $error("channel beat loaded while output register busy");

  a_no_rx_in_unpack: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_issue || cmd.rd_load || cmd.emit) |-> !s_tready)
    else $error("input open during unpack or emit");

  a_end_closes_rx: assert property (@(posedge clk) disable iff (rst)
    cmd.end_frame |=> !s_tready)
    else $error("input reopened right after frame end");
`endif

endmodule

// ===== sv/rlfp_dp.sv =====
// datapath: config registers, frame store, crc, bit unpacker and output register
`timescale 1ns / 1ps

module rlfp_dp import rlfp_pkg::*; #(
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic [7:0]             s_tdata,
  input  cmd_t                   cmd,
  output status_t                st,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [((4+CHANNEL_BITS+11+7)/8)*8-1:0] m_tdata,
  output logic                   m_tuser,
  output logic                   m_tlast
);

  localparam int AW         = $clog2(FRAME_BYTES);
  localparam int CNT_W      = $clog2(FRAME_BYTES + 1);
  localparam int UNPACK_END = FIRST_PAYLOAD + (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
  localparam int RPTR_MAX   = (FRAME_BYTES > UNPACK_END) ? FRAME_BYTES : UNPACK_END;
  localparam int RPTR_W     = $clog2(RPTR_MAX + 1);
  localparam int ACC_W      = CHANNEL_BITS + 8;
  localparam int HAVE_W     = $clog2(ACC_W + 1);
  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TDATA_W    = ((4 + CHANNEL_BITS + 11 + 7) / 8) * 8;
  localparam int D_W        = CHANNEL_BITS + 7;

  logic [7:0]              sync_byte;
  logic [7:0]              rc_frame_type;
  logic [7:0]              crc_polynomial;
  logic [5:0]              min_rc_length;

  logic [CNT_W-1:0]        count;
  logic [7:0]              frame_len;
  logic [7:0]              crc;
  logic [7:0]              ftype;
  logic                    frame_ok;
  logic [RPTR_W-1:0]       rptr;
  logic                    rd_beyond;
  logic [ACC_W-1:0]        acc;
  logic [HAVE_W-1:0]       have;
  logic [CH_W-1:0]         ch;
  logic [CHANNEL_BITS-1:0] raw_q [NUM_CHANNELS];

  logic                    ram_we;
  logic [7:0]              ram_rdata;
  logic [7:0]              rd_byte;
  logic [CHANNEL_BITS-1:0] raw_sel;
  logic [10:0]             pwm_sel;

  function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] poly);
    logic [7:0] r;
    r = c;
    for (int b = 0; b < 8; b++) begin
      r = r[7] ? ((r << 1) ^ poly) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [10:0] map_pwm(input logic [CHANNEL_BITS-1:0] raw);
    logic signed [D_W-1:0] d;
    logic signed [D_W-1:0] p;
    logic signed [D_W-1:0] q;
    logic signed [D_W-1:0] v;
    d = $signed(D_W'(raw)) - $signed(D_W'(RAW_CENTER));
    p = (d <<< 2) + d;
    q = p[D_W-1] ? ((p + $signed(D_W'(7))) >>> 3) : (p >>> 3);
    v = q + $signed(D_W'(PWM_CENTER));
    if (v > $signed(D_W'(PWM_MAX))) begin
      v = $signed(D_W'(PWM_MAX));
    end else if (v < $signed(D_W'(PWM_MIN))) begin
      v = $signed(D_W'(PWM_MIN));
    end
    return v[10:0];
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_byte      <= SYNC_BYTE_RST;
      rc_frame_type  <= RC_FRAME_TYPE_RST;
      crc_polynomial <= CRC_POLYNOMIAL_RST;
      min_rc_length  <= MIN_RC_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC_BYTE:      sync_byte      <= cfg_data;
        REG_RC_FRAME_TYPE:  rc_frame_type  <= cfg_data;
        REG_CRC_POLYNOMIAL: crc_polynomial <= cfg_data;
        REG_MIN_RC_LENGTH:  min_rc_length  <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  assign ram_we = cmd.take_sync || cmd.take_len || cmd.take_body;

  rlfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (s_tdata),
    .raddr (rptr[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_byte = rd_beyond ? 8'd0 : ram_rdata;

  // frame reception and crc
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.abort || cmd.end_frame) begin
      count <= '0;
    end else if (ram_we) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_len) begin
      frame_len <= s_tdata;
      crc       <= 8'd0;
    end else if (cmd.take_body && (9'(count) <= {1'b0, frame_len})) begin
      crc <= crc8_byte(crc ^ s_tdata, crc_polynomial);
    end
    if (cmd.take_body && (count == CNT_W'(TYPE_POS))) begin
      ftype <= s_tdata;
    end
  end

  assign st.sync_match = (s_tdata == sync_byte);
  assign st.len_ok     = (s_tdata > 8'(MIN_LEN_EXCL)) &&
                         (9'(s_tdata) <= 9'(FRAME_BYTES - 2));
  assign st.body_done  = (9'(count) == ({1'b0, frame_len} + 9'd1));
  assign st.pass_now   = (crc == s_tdata) && (ftype == rc_frame_type) &&
                         (frame_len >= {2'b00, min_rc_length});
  assign st.frame_ok   = frame_ok;
  assign st.have_enough = (have >= HAVE_W'(CHANNEL_BITS));
  assign st.out_free   = !m_tvalid || m_tready;
  assign st.last_ch    = (ch == CH_W'(NUM_CHANNELS - 1));

  // channel unpacking
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_ok <= 1'b0;
      ch       <= '0;
      have     <= '0;
      rptr     <= '0;
    end else if (cmd.end_frame) begin
      frame_ok <= st.pass_now;
      ch       <= '0;
      have     <= '0;
      rptr     <= RPTR_W'(FIRST_PAYLOAD);
    end else begin
      if (cmd.rd_issue) begin
        rptr <= rptr + RPTR_W'(1);
      end
      if (cmd.rd_load) begin
        have <= have + HAVE_W'(8);
      end
      if (cmd.emit) begin
        ch <= ch + CH_W'(1);
        if (frame_ok) begin
          have <= have - HAVE_W'(CHANNEL_BITS);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_beyond <= (rptr >= RPTR_W'(FRAME_BYTES));
    if (cmd.end_frame) begin
      acc <= '0;
    end else if (cmd.rd_load) begin
      acc <= acc | (ACC_W'(rd_byte) << have);
    end else if (cmd.emit && frame_ok) begin
      acc <= acc >> CHANNEL_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        raw_q[i] <= '0;
      end
    end else if (cmd.emit && frame_ok) begin
      raw_q[ch] <= acc[CHANNEL_BITS-1:0];
    end
  end

  assign raw_sel = frame_ok ? acc[CHANNEL_BITS-1:0] : raw_q[ch];
  assign pwm_sel = map_pwm(raw_sel);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= TDATA_W'({pwm_sel, raw_sel, 4'(ch)});
      m_tuser <= frame_ok;
      m_tlast <= st.last_ch;
    end
  end

endmodule

// ===== sv/rc_link_frame_parser_unit.sv =====
// Byte-serial parser for packed rc channel frames.
// The s_ channel takes one received byte per beat. The block hunts for
// the sync byte, takes a length byte (4 up to FRAME_BYTES-2, else it drops
// back to hunting), then collects that many bytes into a frame store while
// running the crc-8 over type and payload as they arrive.
// The input stays ready while a frame is received. At the last byte of a
// frame the input closes and NUM_CHANNELS beats go out on the m_ channel.
// A failed frame repeats the held raw values with tuser low, one beat per
// cycle while m_tready stays high, loading its first beat from the EMIT
// state. A good frame reads its payload one byte at a time (single read
// port, registered read): READ issues each address, LOAD merges the byte
// into the bit buffer, and EMIT loads a beat or goes back to READ when too
// few bits are buffered. tlast marks the final channel.
// A stall on m_tready holds the output register, but the unpacker reads on
// until a beat's bits are buffered; input reopens once the last channel is
// loaded, even while it still waits.
// Reset restores register defaults, zeroes the held channel values and
// returns to sync hunting; the frame store is not cleared.
// Config writes land on cfg_we and are meant for idle periods only.
`timescale 1ns / 1ps

module rc_link_frame_parser_unit import rlfp_pkg::*; #(
  parameter int FRAME_BYTES  = FRAME_BYTES_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // rx_byte
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // channel_index, raw_value, pwm_value, zero pad
  output logic [((4+CHANNEL_BITS+11+7)/8)*8-1:0] m_tdata,
  output logic                 m_tuser,   // frame_valid
  output logic                 m_tlast
);

  cmd_t    cmd;
  status_t st;

  rlfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  rlfp_dp #(
    .FRAME_BYTES  (FRAME_BYTES),
    .NUM_CHANNELS (NUM_CHANNELS),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .st        (st),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== verif/rc_link_frame_parser_unit_checker.sv =====
// checker for the rc link frame parser: tracks byte beats, predicts channel beats, compares
`timescale 1ns / 1ps

module rc_link_frame_parser_unit_checker import rlfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // rx_byte
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [31:0]          m_tdata,   // channel_index, raw_value, pwm_value, zero pad
  input  logic                 m_tuser,   // frame_valid
  input  logic                 m_tlast,
  output int                   errors,
  output int                   pending
);

  typedef enum logic [1:0] {
    HUNT_SYNC,
    TAKE_LEN,
    TAKE_BODY
  } hunt_phase_t;

  typedef struct packed {
    logic [3:0]  chan;
    logic [10:0] raw;
    logic [10:0] pwm;
    logic        good;
    logic        last;
  } chan_beat_t;

  hunt_phase_t phase;
  logic [7:0]  sync_val;
  logic [7:0]  type_val;
  logic [7:0]  poly_val;
  int          min_len;
  int          rx_count;
  int          frame_len;
  logic [7:0]  frame_copy [0:FRAME_BYTES_DEF-1];
  logic [10:0] raw_hold [0:NUM_CHANNELS_DEF-1];
  chan_beat_t  chan_beats_due [$];

  always @(posedge clk) begin
    chan_beat_t  want;
    logic [7:0]  b;
    logic [7:0]  crc;
    logic [31:0] acc;
    logic        ok;
    int          have, idx, i, k, ch, pwm;
    if (rst) begin
      phase = HUNT_SYNC;
      sync_val = SYNC_BYTE_RST;
      type_val = RC_FRAME_TYPE_RST;
      poly_val = CRC_POLYNOMIAL_RST;
      min_len = int'(MIN_RC_LENGTH_RST);
      rx_count = 0;
      frame_len = 0;
      for (i = 0; i < FRAME_BYTES_DEF; i++) frame_copy[i] = 8'h00;
      for (i = 0; i < NUM_CHANNELS_DEF; i++) raw_hold[i] = 11'd0;
      chan_beats_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (chan_beats_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected channel beat ch %0d raw %0d pwm %0d valid %0b last %0b",
                   $time, m_tdata[3:0], m_tdata[14:4], m_tdata[25:15], m_tuser, m_tlast);
        end else begin
          want = chan_beats_due.pop_front();
          if (m_tdata[3:0] !== want.chan || m_tdata[14:4] !== want.raw ||
              m_tdata[25:15] !== want.pwm || m_tuser !== want.good ||
              m_tlast !== want.last) begin
            errors++;
            $display("%0t: expected ch %0d raw %0d pwm %0d valid %0b last %0b",
                     $time, want.chan, want.raw, want.pwm, want.good, want.last);
            $display("%0t:   actual ch %0d raw %0d pwm %0d valid %0b last %0b",
                     $time, m_tdata[3:0], m_tdata[14:4], m_tdata[25:15], m_tuser, m_tlast);
          end
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SYNC_BYTE:      sync_val = cfg_data;
          REG_RC_FRAME_TYPE:  type_val = cfg_data;
          REG_CRC_POLYNOMIAL: poly_val = cfg_data;
          REG_MIN_RC_LENGTH:  min_len = int'(cfg_data[5:0]);
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        b = s_tdata;
        case (phase)
          HUNT_SYNC: begin
            if (b == sync_val) begin
              frame_copy[0] = b;
              rx_count = 1;
              phase = TAKE_LEN;
            end
          end
          TAKE_LEN: begin
            frame_len = int'(b);
            if (frame_len > MIN_LEN_EXCL && frame_len <= FRAME_BYTES_DEF - 2) begin
              frame_copy[1] = b;
              rx_count = 2;
              phase = TAKE_BODY;
            end else begin
              rx_count = 0;
              phase = HUNT_SYNC;
            end
          end
          default: begin
            frame_copy[rx_count] = b;
            rx_count++;
            if (rx_count == frame_len + 2) begin
              // crc-8 msb first over type and payload
              crc = 8'h00;
              for (i = TYPE_POS; i <= frame_len; i++) begin
                crc = crc ^ frame_copy[i];
                for (k = 0; k < 8; k++)
                  crc = crc[7] ? ((crc << 1) ^ poly_val) : (crc << 1);
              end
              ok = (crc == frame_copy[frame_len + 1]) && (frame_copy[TYPE_POS] == type_val) &&
                   (frame_len >= min_len);
              if (ok) begin
                acc = 32'd0;
                have = 0;
                idx = FIRST_PAYLOAD;
                for (ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
                  while (have < CHANNEL_BITS_DEF) begin
                    acc = acc | ({24'd0, frame_copy[idx]} << have);
                    idx++;
                    have += 8;
                  end
                  raw_hold[ch] = acc[10:0];
                  acc = acc >> CHANNEL_BITS_DEF;
                  have -= CHANNEL_BITS_DEF;
                end
              end
              for (ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
                pwm = PWM_CENTER + (5 * (int'(raw_hold[ch]) - RAW_CENTER)) / 8;
                if (pwm > PWM_MAX) pwm = PWM_MAX;
                if (pwm < PWM_MIN) pwm = PWM_MIN;
                want.chan = ch[3:0];
                want.raw = raw_hold[ch];
                want.pwm = pwm[10:0];
                want.good = ok;
                want.last = (ch == NUM_CHANNELS_DEF - 1);
                chan_beats_due.push_back(want);
              end
              rx_count = 0;
              phase = HUNT_SYNC;
            end
          end
        endcase
      end
    end
    pending = chan_beats_due.size();
  end

endmodule

// ===== verif/rc_link_frame_parser_unit_tb.sv =====
// testbench top for the rc link frame parser: frame stimulus, stalls, watchdog and verdict
`timescale 1ns / 1ps

module rc_link_frame_parser_unit_tb;
  import rlfp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 64;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = 8'h00;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;   // rx_byte
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [31:0]          m_tdata;           // channel_index, raw_value, pwm_value, zero pad
  logic                 m_tuser;           // frame_valid
  logic                 m_tlast;

  int         mismatch_count;
  int         beats_due;
  int         idle_cycles = 0;
  int         frame_bytes = 0;
  bit         src_gaps = 1'b1;
  bit         sink_gaps = 1'b1;
  bit         hold_req = 1'b0;
  logic [7:0] cur_sync = SYNC_BYTE_RST;
  logic [7:0] cur_type = RC_FRAME_TYPE_RST;
  logic [7:0] cur_poly = CRC_POLYNOMIAL_RST;
  int         cur_min = int'(MIN_RC_LENGTH_RST);

  rc_link_frame_parser_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  rc_link_frame_parser_unit_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .errors(mismatch_count), .pending(beats_due)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_tready <= !(sink_gaps && $urandom_range(99, 0) < 31);
    end
  end

  task automatic send_beat(input logic [7:0] b);
    while (src_gaps && $urandom_range(99, 0) < 31) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SYNC_BYTE:      cur_sync = val;
      REG_RC_FRAME_TYPE:  cur_type = val;
      REG_CRC_POLYNOMIAL: cur_poly = val;
      REG_MIN_RC_LENGTH:  cur_min = int'(val[5:0]);
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic configure(input logic [7:0] sync, input logic [7:0] ftype,
                           input logic [7:0] poly, input logic [5:0] min_length);
    drain();
    write_reg(REG_SYNC_BYTE, sync);
    write_reg(REG_RC_FRAME_TYPE, ftype);
    write_reg(REG_CRC_POLYNOMIAL, poly);
    write_reg(REG_MIN_RC_LENGTH, {2'b00, min_length});
  endtask

  // sync, length, type, payload with packed channels, crc
  task automatic send_frame(input int len, input logic [7:0] ftype, input bit bad_crc);
    logic [175:0] chans;
    logic [7:0]   body [$];
    logic [7:0]   crc;
    int           ch, i, k;
    for (ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
      case ($urandom_range(7, 0))
        0: chans[ch*11 +: 11] = 11'd0;
        1: chans[ch*11 +: 11] = 11'd2047;
        2: chans[ch*11 +: 11] = 11'd992;
        3: chans[ch*11 +: 11] = 11'd991;
        4: chans[ch*11 +: 11] = 11'd990;
        5: chans[ch*11 +: 11] = 11'($urandom_range(1811, 172));
        default: chans[ch*11 +: 11] = 11'($urandom_range(2047, 0));
      endcase
    end
    body.push_back(ftype);
    for (i = 0; i < len - 2; i++)
      body.push_back(i < 22 ? chans[i*8 +: 8] : 8'($urandom));
    crc = 8'h00;
    for (i = 0; i < body.size(); i++) begin
      crc = crc ^ body[i];
      for (k = 0; k < 8; k++)
        crc = crc[7] ? ((crc << 1) ^ cur_poly) : (crc << 1);
    end
    if (bad_crc) crc = crc ^ 8'($urandom_range(255, 1));
    send_beat(cur_sync);
    send_beat(len[7:0]);
    for (i = 0; i < body.size(); i++) send_beat(body[i]);
    send_beat(crc);
    frame_bytes += len + 2;
  endtask

  task automatic random_frames(input int target);
    int         start, r, lo, len, n;
    logic [7:0] nb;
    start = frame_bytes;
    while (frame_bytes - start < target) begin
      r = $urandom_range(99, 0);
      lo = (cur_min < 4) ? 4 : cur_min;
      len = (lo <= 24 && $urandom_range(3, 0) != 0) ? 24 : $urandom_range(62, lo);
      if (r < 60) begin
        send_frame(len, cur_type, 1'b0);
      end else if (r < 70) begin
        send_frame(len, cur_type, 1'b1);
      end else if (r < 78) begin
        send_frame(len, cur_type ^ 8'($urandom_range(255, 1)), 1'b0);
      end else if (r < 86) begin
        send_frame($urandom_range(62, 4), 8'($urandom), 1'($urandom_range(1, 0)));
      end else if (r < 93) begin
        // length byte out of range
        send_beat(cur_sync);
        send_beat($urandom_range(1, 0) ? 8'($urandom_range(3, 0)) : 8'($urandom_range(255, 63)));
      end else begin
        n = $urandom_range(4, 1);
        repeat (n) begin
          do nb = 8'($urandom); while (nb == cur_sync);
          send_beat(nb);
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: noise, bad lengths, good / bad crc, shortest length
    send_beat(8'h00);
    send_beat(8'hFF);
    send_beat(cur_sync);
    send_beat(8'd3);
    send_beat(cur_sync);
    send_beat(8'd63);
    send_frame(24, cur_type, 1'b0);
    send_frame(24, cur_type, 1'b1);
    send_frame(4, cur_type, 1'b0);

    // long receiver hold while the next frame is already offered
    hold_req = 1'b1;
    send_frame(24, cur_type, 1'b0);
    send_frame(24, cur_type ^ 8'h01, 1'b0);

    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    configure(8'h00, 8'hFF, 8'h07, 6'd4);
    write_reg(REG_UNUSED, 8'hA5);
    random_frames(30);

    src_gaps = 1'b1;
    sink_gaps = 1'b1;
    configure(8'hFF, 8'h00, 8'h00, 6'd62);
    random_frames(20);

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && beats_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== rc_link_frame_parser_unit.f =====
sv/rlfp_pkg.sv
sv/rlfp_ram.sv
sv/rlfp_ctrl.sv
sv/rlfp_dp.sv
sv/rc_link_frame_parser_unit.sv
verif/rc_link_frame_parser_unit_checker.sv
verif/rc_link_frame_parser_unit_tb.sv
